>>> hw/rtl/upp_pkg.sv
// Shared types, constants and register defaults for the UPS status poll parser.
package upp_pkg;

   localparam int FIELD_COUNT_DEFAULT = 8;

   // result queue; depth must be a power of two
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_LEVEL_W = $clog2(RSP_DEPTH + 2);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int VALUE_FIELDS = 6;
   localparam int VALUE_W      = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUERY_PERIOD   = 3'd0,
      CSR_RESP_TIMEOUT   = 3'd1,
      CSR_MAX_ATTEMPTS   = 3'd2,
      CSR_FLOAT_THRESH   = 3'd3,
      CSR_FAST_THRESH    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_READING = 2'd1,
      KIND_NORESP  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      MODE_UNKNOWN  = 3'd0,
      MODE_NORESP   = 3'd1,
      MODE_INVERTER = 3'd2,
      MODE_BYPASS   = 3'd3,
      MODE_FAST     = 3'd4,
      MODE_FLOAT    = 3'd5
   } mode_type;

   localparam logic [7:0] CHAR_Q     = 8'h51;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   localparam logic [1:0] QUERY_LAST_BEAT = 2'd2;

   typedef struct packed {
      logic [7:0]  query_period_s;
      logic [7:0]  response_timeout_s;
      logic [3:0]  max_attempts;
      logic [15:0] float_threshold_cv;
      logic [15:0] fast_threshold_cv;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      query_period_s:     8'd5,
      response_timeout_s: 8'd5,
      max_attempts:       4'd2,
      float_threshold_cv: 16'd2700,
      fast_threshold_cv:  16'd2880
   };

   // one queue entry; a KIND_TX entry expands to the three query bytes
   typedef struct packed {
      kind_type                              kind;
      logic [VALUE_FIELDS-1:0][VALUE_W-1:0]  values;
      logic [7:0]                            flags;
      mode_type                              mode;
   } desc_type;

endpackage

>>> hw/rtl/upp_if.sv
// Request and response channel interfaces of the UPS status poll parser.
interface upp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface upp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  tx_byte;
   logic [15:0] in_volts;
   logic [15:0] in_fault_volts;
   logic [15:0] out_volts;
   logic [15:0] out_load;
   logic [15:0] out_freq;
   logic [15:0] battery_cv;
   logic [7:0]  status_bits;
   logic [2:0]  inverter_mode;
   logic        last;

   modport source (output valid, output result_kind, output tx_byte, output in_volts,
                   output in_fault_volts, output out_volts, output out_load,
                   output out_freq, output battery_cv, output status_bits,
                   output inverter_mode, output last, input ready);
   modport sink   (input valid, input result_kind, input tx_byte, input in_volts,
                   input in_fault_volts, input out_volts, input out_load,
                   input out_freq, input battery_cv, input status_bits,
                   input inverter_mode, input last, output ready);
endinterface

>>> hw/rtl/ups_status_poll_parser.sv
// UPS status poll parser: top level with control registers, parser engine and result queue.
// One request (a received serial byte or a one-second tick) is taken per clock cycle while
// req ready is high. Each request is registered, then processed in the following cycle against
// the poll and parser state; a request that produces results places one entry in a four-entry
// result queue at the edge after the one that accepted it. A query entry drains as three
// response beats (Q, 1, CR, the last marked), a reading or no-response entry as one. req ready
// drops while queued entries plus the request in flight fill the queue, so sustained rate is
// one request per cycle while responses are taken, and lower when ticks trigger queries back
// to back. The user must write control registers through the csr port only while the block
// is idle; the block itself does not enforce this.
module ups_status_poll_parser
   import upp_pkg::*;
#(
   parameter int FIELD_COUNT = FIELD_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   upp_req_if.sink                req_chan,
   upp_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                cfg_ff;
   logic                   push;
   desc_type               push_desc;
   logic [RSP_LEVEL_W-1:0] q_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUERY_PERIOD: cfg_ff.query_period_s     <= csr_wdata[7:0];
            CSR_RESP_TIMEOUT: cfg_ff.response_timeout_s <= csr_wdata[7:0];
            CSR_MAX_ATTEMPTS: cfg_ff.max_attempts       <= csr_wdata[3:0];
            CSR_FLOAT_THRESH: cfg_ff.float_threshold_cv <= csr_wdata;
            CSR_FAST_THRESH:  cfg_ff.fast_threshold_cv  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   upp_engine #(
      .FIELD_COUNT (FIELD_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_chan.valid),
      .req_cmd     (req_chan.cmd),
      .req_rx_byte (req_chan.rx_byte),
      .req_ready   (req_chan.ready),
      .q_level     (q_level),
      .push        (push),
      .push_desc   (push_desc)
   );

   upp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .level     (q_level),
      .rsp       (rsp_chan)
   );

endmodule

>>> hw/rtl/upp_engine.sv
// Request register, poll timing, reply parser and classification.
module upp_engine
   import upp_pkg::*;
#(
   parameter int FIELD_COUNT = FIELD_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   input  logic [7:0]             req_rx_byte,
   output logic                   req_ready,
   input  logic [RSP_LEVEL_W-1:0] q_level,
   output logic                   push,
   output desc_type               push_desc
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SENT  = 3'b010,
      PH_REPLY = 3'b100
   } phase_type;

   logic       req_valid_ff;
   logic       req_cmd_ff;
   logic [7:0] req_byte_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] sec_ff, sec_in;
   logic       never_ff, never_in;
   logic [3:0] tcount_ff, tcount_in;
   logic [3:0] fidx_ff, fidx_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0] fdig_ff, fdig_in;
   logic       point_ff, point_in;
   logic       stopped_ff, stopped_in;
   logic [VALUE_FIELDS-1:0][VALUE_W-1:0] values_ff, values_in, values_commit;
   logic [7:0] flags_ff, flags_in;

   logic       accept;
   logic       do_query;
   logic [7:0] sec_inc;
   logic [3:0] tcount_inc;
   logic       is_digit;
   logic [19:0] mac;
   logic [15:0] mac_sat;
   logic [22:0] acc_wide;
   logic [22:0] scaled;
   logic [15:0] commit_value;
   mode_type   cls_mode;

   assign req_ready = (q_level + RSP_LEVEL_W'(req_valid_ff)) < RSP_LEVEL_W'(RSP_DEPTH);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_cmd_ff  <= req_cmd;
         req_byte_ff <= req_rx_byte;
      end
   end

   assign sec_inc    = (sec_ff == 8'hFF) ? sec_ff : sec_ff + 8'd1;
   assign tcount_inc = (tcount_ff == 4'hF) ? tcount_ff : tcount_ff + 4'd1;
   assign is_digit   = (req_byte_ff >= CHAR_ZERO) && (req_byte_ff <= CHAR_NINE);

   assign mac     = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                    + 20'(req_byte_ff[3:0]);
   assign mac_sat = (mac > 20'd65535) ? 16'hFFFF : mac[15:0];

   // scale to hundredths
   assign acc_wide = {7'b0, accum_ff};
   always_comb begin
      unique case (fdig_ff)
         2'd0:    scaled = (acc_wide << 6) + (acc_wide << 5) + (acc_wide << 2);
         2'd1:    scaled = (acc_wide << 3) + (acc_wide << 1);
         default: scaled = acc_wide;
      endcase
   end
   assign commit_value = (scaled > 23'd65535) ? 16'hFFFF : scaled[15:0];

   always_comb begin
      values_commit = values_ff;
      if (fidx_ff < 4'(VALUE_FIELDS)) begin
         values_commit[fidx_ff[2:0]] = commit_value;
      end
   end

   always_comb begin
      priority if (flags_ff[7]) begin
         cls_mode = MODE_INVERTER;
      end else if (values_commit[5] >= cfg.fast_threshold_cv) begin
         cls_mode = MODE_FAST;
      end else if (values_commit[5] >= cfg.float_threshold_cv) begin
         cls_mode = MODE_FLOAT;
      end else begin
         cls_mode = MODE_BYPASS;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      sec_in     = sec_ff;
      never_in   = never_ff;
      tcount_in  = tcount_ff;
      fidx_in    = fidx_ff;
      accum_in   = accum_ff;
      fdig_in    = fdig_ff;
      point_in   = point_ff;
      stopped_in = stopped_ff;
      values_in  = values_ff;
      flags_in   = flags_ff;
      do_query   = 1'b0;
      push       = 1'b0;
      push_desc  = '0;

      if (req_valid_ff) begin
         if (req_cmd_ff) begin
            sec_in = sec_inc;
            if (phase_ff == PH_IDLE) begin
               if (never_ff || sec_inc >= cfg.query_period_s) begin
                  do_query = 1'b1;
               end
            end else if (sec_inc >= cfg.response_timeout_s) begin
               if (tcount_inc < cfg.max_attempts) begin
                  tcount_in = tcount_inc;
                  do_query  = 1'b1;
               end else begin
                  tcount_in      = 4'd0;
                  phase_in       = PH_IDLE;
                  never_in       = 1'b1;
                  push           = 1'b1;
                  push_desc.kind = KIND_NORESP;
                  push_desc.mode = MODE_NORESP;
               end
            end
            if (do_query) begin
               sec_in         = 8'd0;
               never_in       = 1'b0;
               phase_in       = PH_SENT;
               push           = 1'b1;
               push_desc.kind = KIND_TX;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_SENT: begin
                  if (req_byte_ff == CHAR_OPEN) begin
                     phase_in   = PH_REPLY;
                     fidx_in    = 4'd0;
                     accum_in   = 16'd0;
                     fdig_in    = 2'd0;
                     point_in   = 1'b0;
                     stopped_in = 1'b0;
                     values_in  = '0;
                     flags_in   = 8'd0;
                  end
               end
               PH_REPLY: begin
                  priority if (req_byte_ff == CHAR_SPACE) begin
                     values_in  = values_commit;
                     accum_in   = 16'd0;
                     fdig_in    = 2'd0;
                     point_in   = 1'b0;
                     stopped_in = 1'b0;
                     if (fidx_ff < 4'(FIELD_COUNT)) begin
                        fidx_in = fidx_ff + 4'd1;
                     end
                  end else if (req_byte_ff == CHAR_CR) begin
                     values_in        = values_commit;
                     accum_in         = 16'd0;
                     fdig_in          = 2'd0;
                     point_in         = 1'b0;
                     stopped_in       = 1'b0;
                     tcount_in        = 4'd0;
                     phase_in         = PH_IDLE;
                     push             = 1'b1;
                     push_desc.kind   = KIND_READING;
                     push_desc.values = values_commit;
                     push_desc.flags  = flags_ff;
                     push_desc.mode   = cls_mode;
                  end else if (fidx_ff < 4'(FIELD_COUNT)) begin
                     if (fidx_ff == 4'd7) begin
                        // status field: accum counts characters taken
                        if (accum_ff < 16'd8) begin
                           flags_in = {flags_ff[6:0], req_byte_ff == CHAR_ONE};
                           accum_in = accum_ff + 16'd1;
                        end
                     end else if (fidx_ff < 4'(VALUE_FIELDS) && !stopped_ff) begin
                        if (is_digit) begin
                           if (!(point_ff && fdig_ff >= 2'd2)) begin
                              accum_in = mac_sat;
                              if (point_ff) begin
                                 fdig_in = fdig_ff + 2'd1;
                              end
                           end
                        end else if (req_byte_ff == CHAR_POINT && !point_ff) begin
                           point_in = 1'b1;
                        end else begin
                           stopped_in = 1'b1;
                        end
                     end
                  end else begin
                     // fields past the field count are ignored
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         sec_ff     <= 8'd0;
         never_ff   <= 1'b1;
         tcount_ff  <= 4'd0;
         fidx_ff    <= 4'd0;
         accum_ff   <= 16'd0;
         fdig_ff    <= 2'd0;
         point_ff   <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         sec_ff     <= sec_in;
         never_ff   <= never_in;
         tcount_ff  <= tcount_in;
         fidx_ff    <= fidx_in;
         accum_ff   <= accum_in;
         fdig_ff    <= fdig_in;
         point_ff   <= point_in;
         stopped_ff <= stopped_in;
      end
      values_ff <= values_in;
      flags_ff  <= flags_in;
   end

   a_never_idle: assert property (@(posedge clock) disable iff (reset)
      never_ff |-> phase_ff == PH_IDLE)
      else $error("pending first query while link not idle");

   a_fidx_range: assert property (@(posedge clock) disable iff (reset)
      fidx_ff <= 4'(FIELD_COUNT))
      else $error("field index past field count");

endmodule

>>> hw/rtl/upp_rsp_queue.sv
// Result queue that expands query entries into the three transmit bytes.
module upp_rsp_queue
   import upp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  desc_type               push_desc,
   output logic [RSP_LEVEL_W-1:0] level,
   upp_rsp_if.source              rsp
);

   desc_type               mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RSP_LEVEL_W-1:0] count_ff, count_in;
   logic [1:0]             beat_ff;
   desc_type               head;
   logic                   pop;
   logic                   done;
   logic                   is_tx;

   assign head  = mem_ff[rd_ptr_ff];
   assign is_tx = head.kind == KIND_TX;
   assign level = count_ff;

   assign rsp.valid          = count_ff != '0;
   assign rsp.result_kind    = head.kind;
   assign rsp.in_volts       = head.values[0];
   assign rsp.in_fault_volts = head.values[1];
   assign rsp.out_volts      = head.values[2];
   assign rsp.out_load       = head.values[3];
   assign rsp.out_freq       = head.values[4];
   assign rsp.battery_cv     = head.values[5];
   assign rsp.status_bits    = head.flags;
   assign rsp.inverter_mode  = head.mode;
   assign rsp.last           = !is_tx || beat_ff == QUERY_LAST_BEAT;

   always_comb begin
      if (!is_tx) begin
         rsp.tx_byte = 8'd0;
      end else begin
         unique case (beat_ff)
            2'd0:    rsp.tx_byte = CHAR_Q;
            2'd1:    rsp.tx_byte = CHAR_ONE;
            default: rsp.tx_byte = CHAR_CR;
         endcase
      end
   end

   assign pop      = rsp.valid && rsp.ready;
   assign done     = pop && rsp.last;
   assign count_in = count_ff + RSP_LEVEL_W'(push) - RSP_LEVEL_W'(done);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         beat_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (done) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
            beat_ff   <= 2'd0;
         end else if (pop) begin
            beat_ff <= beat_ff + 2'd1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < RSP_LEVEL_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_beat_on_query: assert property (@(posedge clock) disable iff (reset)
      beat_ff != 2'd0 |-> rsp.valid && is_tx)
      else $error("query byte counter active without a query entry");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UPS status poll parser: polls, replies and retries vs a predictor.
module testbench;
   import upp_pkg::*;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS = 10;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   typedef enum logic [1:0] {LINK_IDLE, LINK_SENT, LINK_REPLY} link_type;

   typedef struct packed {
      kind_type                             kind;
      logic [7:0]                           tx;
      logic [VALUE_FIELDS-1:0][VALUE_W-1:0] vals;
      logic [7:0]                           flags;
      mode_type                             mode;
      logic                                 last;
   } beat_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   upp_req_if req_if();
   upp_rsp_if rsp_if();

   ups_status_poll_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // poller predictor state
   logic [7:0]  period_s;
   logic [7:0]  timeout_s;
   logic [3:0]  attempts_max;
   logic [15:0] float_cv;
   logic [15:0] fast_cv;
   link_type    link;
   mode_type    mode_now;
   int unsigned secs;
   int unsigned timeouts;
   int unsigned field_idx;
   int unsigned accum;
   int unsigned frac;
   logic        never_polled;
   logic        point_seen;
   logic        num_stopped;
   logic [VALUE_FIELDS-1:0][VALUE_W-1:0] reading;
   logic [7:0]  flags;

   beat_type    pending_beats[$];
   logic [7:0]  line_q[$];
   int          mismatches;
   int unsigned counted_items;
   int          idle_pct;
   int          stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[ups_status_poll_parser] ERROR");
      $finish;
   end

   always @(posedge clock) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   function automatic void clear_number();
      accum = 0;
      frac = 0;
      point_seen = 1'b0;
      num_stopped = 1'b0;
   endfunction

   function automatic void add_beat(beat_type b);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      line_q.insert(line_q.size(), b);
   endfunction

   function automatic void close_field();
      int unsigned v;
      v = accum;
      if (field_idx < VALUE_FIELDS) begin
         if (frac == 0) v = v * 100;
         else if (frac == 1) v = v * 10;
         if (v > 65535) v = 65535;
         reading[field_idx] = v[15:0];
      end
      clear_number();
   endfunction

   function automatic void take_char(logic [7:0] ch);
      if (field_idx == 7) begin
         if (accum < 8) begin
            flags = {flags[6:0], ch == CHAR_ONE};
            accum++;
         end
      end else if (field_idx < VALUE_FIELDS && !num_stopped) begin
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            if (!(point_seen && frac >= 2)) begin
               accum = accum * 10 + (ch - CHAR_ZERO);
               if (accum > 65535) accum = 65535;
               if (point_seen) frac++;
            end
         end else if (ch == CHAR_POINT && !point_seen) begin
            point_seen = 1'b1;
         end else begin
            num_stopped = 1'b1;
         end
      end
   endfunction

   function automatic void queue_query();
      beat_type   q;
      logic [7:0] text [3];
      text = '{CHAR_Q, CHAR_ONE, CHAR_CR};
      for (int k = 0; k < 3; k++) begin
         q = '0;
         q.kind = KIND_TX;
         q.tx = text[k];
         q.last = (k == 2);
         add_beat(q);
      end
      secs = 0;
      never_polled = 1'b0;
      link = LINK_SENT;
   endfunction

   function automatic void poll_step(logic c, logic [7:0] b);
      beat_type rd;
      rd = '0;
      if (c == CMD_TICK) begin
         if (secs < 255) secs++;
         if (link == LINK_IDLE) begin
            if (never_polled || secs >= period_s) queue_query();
         end else if (secs >= timeout_s) begin
            if (timeouts < 15) timeouts++;
            if (timeouts < attempts_max) begin
               queue_query();
            end else begin
               timeouts = 0;
               mode_now = MODE_NORESP;
               link = LINK_IDLE;
               never_polled = 1'b1;
               rd.kind = KIND_NORESP;
               rd.mode = MODE_NORESP;
               rd.last = 1'b1;
               add_beat(rd);
            end
         end
      end else if (link == LINK_SENT) begin
         if (b == CHAR_OPEN) begin
            link = LINK_REPLY;
            field_idx = 0;
            clear_number();
            reading = '0;
            flags = '0;
         end
      end else if (link == LINK_REPLY) begin
         if (b == CHAR_SPACE) begin
            close_field();
            if (field_idx < FIELD_COUNT_DEFAULT) field_idx++;
         end else if (b != CHAR_CR) begin
            if (field_idx < FIELD_COUNT_DEFAULT) take_char(b);
         end else begin
            close_field();
            if (flags[7]) mode_now = MODE_INVERTER;
            else if (reading[5] >= fast_cv) mode_now = MODE_FAST;
            else if (reading[5] >= float_cv) mode_now = MODE_FLOAT;
            else mode_now = MODE_BYPASS;
            timeouts = 0;
            link = LINK_IDLE;
            rd.kind = KIND_READING;
            rd.vals = reading;
            rd.flags = flags;
            rd.mode = mode_now;
            rd.last = 1'b1;
            add_beat(rd);
         end
      end
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
      end
   endfunction

   always @(negedge clock) begin : check_rsp
      beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response, kind %0d", $realtime, rsp_if.result_kind);
         end else begin
            want = pending_beats.pop_front();
            compare_field("result_kind", 16'(want.kind), 16'(rsp_if.result_kind));
            compare_field("tx_byte", 16'(want.tx), 16'(rsp_if.tx_byte));
            compare_field("in_volts", want.vals[0], rsp_if.in_volts);
            compare_field("in_fault_volts", want.vals[1], rsp_if.in_fault_volts);
            compare_field("out_volts", want.vals[2], rsp_if.out_volts);
            compare_field("out_load", want.vals[3], rsp_if.out_load);
            compare_field("out_freq", want.vals[4], rsp_if.out_freq);
            compare_field("battery_cv", want.vals[5], rsp_if.battery_cv);
            compare_field("status_bits", 16'(want.flags), 16'(rsp_if.status_bits));
            compare_field("inverter_mode", 16'(want.mode), 16'(rsp_if.inverter_mode));
            compare_field("last", 16'(want.last), 16'(rsp_if.last));
         end
      end
   end

   // one request; returns at the edge that accepted it, plus any sender gap
   task automatic push_request(logic c, logic [7:0] b);
      logic took;
      req_if.valid <= 1'b1;
      req_if.cmd <= c;
      req_if.rx_byte <= b;
      do begin
         @(negedge clock);
         took = req_if.ready;
         @(posedge clock);
      end while (!took);
      counted_items++;
      poll_step(c, b);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_tick();
      push_request(CMD_TICK, 8'($urandom_range(255)));
   endtask

   task automatic send_line();
      while (line_q.size() > 0) push_request(CMD_BYTE, line_q.pop_front());
   endtask

   task automatic send_noise();
      repeat ($urandom_range(6, 1))
         push_request(1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(logic [7:0] period, logic [7:0] tmo, logic [3:0] attempts,
                                 logic [15:0] float_th, logic [15:0] fast_th);
      write_reg(CSR_QUERY_PERIOD, {8'd0, period});
      write_reg(CSR_RESP_TIMEOUT, {8'd0, tmo});
      write_reg(CSR_MAX_ATTEMPTS, {12'd0, attempts});
      write_reg(CSR_FLOAT_THRESH, float_th);
      write_reg(CSR_FAST_THRESH, fast_th);
      csr_we <= 1'b0;
      period_s = period;
      timeout_s = tmo;
      attempts_max = attempts;
      float_cv = float_th;
      fast_cv = fast_th;
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_SPACE || b == CHAR_CR);
      return b;
   endfunction

   function automatic void add_number();
      case ($urandom_range(7))
         0: ;
         1: add_text($sformatf("%0d", $urandom_range(99999)));
         2: add_text($sformatf("%0d.%0d", $urandom_range(999), $urandom_range(9999)));
         3: begin
            add_text($sformatf("%0d", $urandom_range(99)));
            add_byte(junk_byte());
            add_text($sformatf("%0d", $urandom_range(99)));
         end
         4: add_text($sformatf("%0d.%0d.%0d", $urandom_range(99), $urandom_range(9),
                               $urandom_range(9)));
         default: add_text($sformatf("%0d.%0d", $urandom_range(300), $urandom_range(9)));
      endcase
   endfunction

   function automatic void add_battery();
      int cv;
      int pick;
      pick = $urandom_range(5);
      case (pick)
         0: cv = int'(float_cv) + int'($urandom_range(6)) - 3;
         1: cv = int'(fast_cv) + int'($urandom_range(6)) - 3;
         2: cv = $urandom_range(65535);
         default: cv = $urandom_range(4000);
      endcase
      if (cv < 0) cv = 0;
      if (cv > 65535) cv = 65535;
      if (pick == 5) add_text($sformatf("%0d", 656 + $urandom_range(9000)));
      else add_text($sformatf("%0d.%02d", cv / 100, cv % 100));
   endfunction

   function automatic void add_status();
      int n;
      logic noisy;
      case ($urandom_range(5))
         0: n = $urandom_range(7);
         1: n = $urandom_range(12, 9);
         default: n = 8;
      endcase
      noisy = ($urandom_range(5) == 0);
      repeat (n) begin
         if (noisy) add_byte(junk_byte());
         else add_byte($urandom_range(1) ? CHAR_ONE : CHAR_ZERO);
      end
   endfunction

   function automatic void build_reply();
      int fields;
      case ($urandom_range(5))
         0: fields = $urandom_range(7, 1);
         1: fields = $urandom_range(12, 9);
         default: fields = 8;
      endcase
      add_byte(CHAR_OPEN);
      for (int f = 0; f < fields; f++) begin
         if (f > 0) add_byte(CHAR_SPACE);
         if (f == 5) add_battery();
         else if (f == 7) add_status();
         else add_number();
      end
      add_byte(CHAR_CR);
   endfunction

   // query, reply mostly well formed; some cut short or with stray bytes
   task automatic run_poll();
      int cut;
      while (link != LINK_SENT) send_tick();
      repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0)
         push_request(CMD_BYTE, junk_byte());
      line_q.delete();
      build_reply();
      if ($urandom_range(7) == 0) begin
         cut = $urandom_range(line_q.size() - 1, 1);
         while (line_q.size() > cut) void'(line_q.pop_back());
      end
      if ($urandom_range(9) == 0 && line_q.size() > 1)
         line_q.insert($urandom_range(line_q.size() - 1, 1), junk_byte());
      send_line();
      repeat ($urandom_range(2)) send_tick();
   endtask

   task automatic run_random(int unsigned target, int idle, int stall);
      int unsigned start;
      idle_pct = idle;
      stall_pct = stall;
      start = counted_items;
      while (counted_items - start < target) begin
         if ($urandom_range(5) == 0) send_noise();
         else run_poll();
      end
      finish_phase();
   endtask

   // saturation, dropped third decimal, second point, sign, empty field
   task automatic test_directed_parse();
      send_tick();
      line_q.delete();
      add_text("(700.1 9.999 1.2.3 -7 ");
      add_byte(CHAR_CR);
      send_line();
      finish_phase();
   endtask

   task automatic test_default_polls();
      run_random(50, 0, 0);
   endtask

   // retry exhaustion, short status field, bare CR reply
   task automatic test_no_response();
      write_settings(8'd1, 8'd1, 4'd1, 16'd0, 16'd0);
      send_tick();
      send_tick();
      send_tick();
      while (link != LINK_SENT) send_tick();
      line_q.delete();
      add_byte(CHAR_OPEN);
      repeat (7) add_byte(CHAR_SPACE);
      add_byte(CHAR_ONE);
      add_byte(CHAR_CR);
      send_line();
      while (link != LINK_SENT) send_tick();
      push_request(CMD_BYTE, CHAR_OPEN);
      push_request(CMD_BYTE, CHAR_CR);
      finish_phase();
   endtask

   task automatic test_fast_retry();
      write_settings(8'd1, 8'd3, 4'd15, 16'd0, 16'hFFFF);
      run_random(40, 45, 0);
   endtask

   task automatic test_slow_poll();
      write_settings(8'd40, 8'd40, 4'd1, 16'hFFFF, 16'hFFFF);
      run_random(40, 0, 45);
   endtask

   task automatic test_close_thresholds();
      write_settings(8'd3, 8'd6, 4'd3, 16'd2500, 16'd2600);
      run_random(40, 24, 24);
   endtask

   task automatic test_random_settings();
      write_settings(8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)),
                     4'($urandom_range(15, 1)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
      run_random(40, 24, 24);
      write_settings(8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)),
                     4'($urandom_range(15, 1)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
      run_random(30, 0, 0);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      counted_items = 0;
      period_s = CFG_RESET.query_period_s;
      timeout_s = CFG_RESET.response_timeout_s;
      attempts_max = CFG_RESET.max_attempts;
      float_cv = CFG_RESET.float_threshold_cv;
      fast_cv = CFG_RESET.fast_threshold_cv;
      link = LINK_IDLE;
      mode_now = MODE_UNKNOWN;
      secs = 0;
      timeouts = 0;
      field_idx = 0;
      never_polled = 1'b1;
      clear_number();
      reading = '0;
      flags = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_parse();
      test_default_polls();
      test_no_response();
      test_fast_retry();
      test_slow_poll();
      test_close_thresholds();
      test_random_settings();

      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("[ups_status_poll_parser] OK");
      end else begin
         $display("[ups_status_poll_parser] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/upp_pkg.sv
hw/rtl/upp_if.sv
hw/rtl/upp_engine.sv
hw/rtl/upp_rsp_queue.sv
hw/rtl/ups_status_poll_parser.sv
tb/sv/testbench.sv
